// ===== rtl/sfad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfad_pkg
// Shared types and constants for the serial frame to advertising data block.
// ----------------------------------------------------------------------------
package sfad_pkg;

  localparam logic [7:0] SYNC_A      = 8'h4E;
  localparam logic [7:0] SYNC_B      = 8'h44;
  localparam logic [7:0] TYPE_INJECT = 8'h01;
  localparam logic [7:0] AD_MANUF    = 8'hFF;
  localparam logic [7:0] AD_LEN_ADD  = 8'd3;

  // Largest payload that is wrapped; the length byte len+3 must fit 8 bits.
  localparam int unsigned MAX_PAYLOAD = 240;

  // Header is four bytes: length, manufacturer type, two signature bytes.
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_IDX   = HDR_IDX_W'(0);
  localparam logic [HDR_IDX_W-1:0] HDR_MANUF_IDX = HDR_IDX_W'(1);
  localparam logic [HDR_IDX_W-1:0] HDR_SIGB_IDX  = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX  = HDR_IDX_W'(HDR_BYTES - 1);

  // Result queue, power of two deep.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HUNT_A = 6'b000001,
    PH_HUNT_B = 6'b000010,
    PH_TYPE   = 6'b000100,
    PH_LEN_LO = 6'b001000,
    PH_LEN_HI = 6'b010000,
    PH_BODY   = 6'b100000
  } phase_t;

  // One queued result: a whole header (expanded at the output) or one byte.
  typedef struct packed {
    logic       is_hdr;
    logic [7:0] data;
    logic       last;
  } entry_t;

  // Push request from the parser to the result queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

// ===== rtl/sfad_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfad_parse
// Sync/type/length frame parser; one byte per transfer, emits queue pushes.
// ----------------------------------------------------------------------------
module sfad_parse #(
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  input  logic              enable,
  output sfad_pkg::push_t   push
);
  import sfad_pkg::*;

  localparam int unsigned LEFT_W = $clog2(BUFFER_BYTES - 4);
  localparam logic [15:0] LEN_BOUND = 16'(BUFFER_BYTES - 5);
  localparam logic [15:0] LEN_FWD   = 16'(MAX_PAYLOAD);

  phase_t              phase, phase_next;
  logic                inject, inject_next;
  logic [7:0]          len_lo, len_lo_next;
  logic [LEFT_W-1:0]   bytes_left, bytes_left_next;
  logic                forwarding, forwarding_next;
  logic [15:0]         len;
  logic                last_byte;

  assign len       = {rx_byte, len_lo};
  assign last_byte = (bytes_left <= LEFT_W'(1));

  always_comb begin
    phase_next      = phase;
    inject_next     = inject;
    len_lo_next     = len_lo;
    bytes_left_next = bytes_left;
    forwarding_next = forwarding;
    push            = '0;
    case (phase)
      PH_HUNT_B: begin
        if (rx_byte == SYNC_B) begin
          phase_next = PH_TYPE;
        end else if (rx_byte == SYNC_A) begin
          phase_next = PH_HUNT_B;
        end else begin
          phase_next = PH_HUNT_A;
        end
      end
      PH_TYPE: begin
        inject_next = (rx_byte == TYPE_INJECT);
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_lo_next = rx_byte;
        phase_next  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        forwarding_next = 1'b0;
        if (len > LEN_BOUND || len == 16'd0) begin
          // drop oversized or empty frames, resume the hunt
          bytes_left_next = '0;
          phase_next      = PH_HUNT_A;
        end else begin
          bytes_left_next = LEFT_W'(len);
          phase_next      = PH_BODY;
          if (enable && inject && len <= LEN_FWD) begin
            forwarding_next   = 1'b1;
            push.push         = fire;
            push.entry.is_hdr = 1'b1;
            push.entry.data   = len[7:0] + AD_LEN_ADD;
            push.entry.last   = 1'b0;
          end
        end
      end
      PH_BODY: begin
        if (forwarding) begin
          push.push         = fire;
          push.entry.is_hdr = 1'b0;
          push.entry.data   = rx_byte;
          push.entry.last   = last_byte;
        end
        if (last_byte) begin
          bytes_left_next = '0;
          forwarding_next = 1'b0;
          phase_next      = PH_HUNT_A;
        end else begin
          bytes_left_next = bytes_left - LEFT_W'(1);
        end
      end
      default: begin
        phase_next = (rx_byte == SYNC_A) ? PH_HUNT_B : PH_HUNT_A;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT_A;
      inject     <= 1'b0;
      len_lo     <= '0;
      bytes_left <= '0;
      forwarding <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      inject     <= inject_next;
      len_lo     <= len_lo_next;
      bytes_left <= bytes_left_next;
      forwarding <= forwarding_next;
    end
  end

  a_fwd_in_body: assert property (@(posedge clk) disable iff (rst)
    forwarding |-> phase == PH_BODY)
    else $error("forwarding set outside payload phase");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_push_fire: assert property (@(posedge clk) disable iff (rst)
    push.push |-> fire)
    else $error("push without an accepted byte");

endmodule

// ===== rtl/sfad_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfad_outq
// Small result queue; a header entry expands into four output bytes.
// ----------------------------------------------------------------------------
module sfad_outq (
  input  logic             clk,
  input  logic             rst,
  input  sfad_pkg::push_t  push,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       ad_byte,
  output logic             first_of_ad,
  output logic             last_of_ad
);
  import sfad_pkg::*;

  entry_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QPTR_W:0]       count;
  logic [HDR_IDX_W-1:0]  sub;
  entry_t                head;
  logic                  out_fire;
  logic                  pop;

  assign head      = entries[rd_ptr];
  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && !out_stall;
  assign pop       = out_fire && (!head.is_hdr || sub == HDR_LAST_IDX);

  always_comb begin
    first_of_ad = 1'b0;
    last_of_ad  = 1'b0;
    ad_byte     = head.data;
    if (head.is_hdr) begin
      case (sub)
        HDR_LEN_IDX: begin
          first_of_ad = 1'b1;
        end
        HDR_MANUF_IDX: ad_byte = AD_MANUF;
        HDR_SIGB_IDX:  ad_byte = SYNC_B;
        default:       ad_byte = SYNC_A;
      endcase
    end else begin
      last_of_ad = head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
        sub    <= '0;
      end else if (out_fire) begin
        // advance through the header bytes
        sub <= sub + HDR_IDX_W'(1);
      end
      case ({push.push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !full)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_sub_header: assert property (@(posedge clk) disable iff (rst)
    sub != '0 |-> out_valid && head.is_hdr)
    else $error("header index set without a header at the head");

endmodule

// ===== rtl/serial_frame_to_ad_wrapper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_to_ad_wrapper_core
// Deframes sync/type/length serial frames and wraps inject payloads as
// manufacturer advertising data.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  config   | enable_we              | enable
//  input    | in_valid / in_stall    | rx_byte
//  output   | out_valid / out_stall  | ad_byte, first_of_ad, last_of_ad
//
//  One input byte per cycle unless the queue is full; each byte is parsed
//  in the cycle it transfers and its results land in a four-entry result
//  queue. A forwarded header expands into four output bytes, so the input
//  stalls only once the queue is full; the output side sets the sustained
//  rate. Synchronous reset returns the parser to the sync hunt, empties the
//  queue and clears enable.
// ----------------------------------------------------------------------------
module serial_frame_to_ad_wrapper_core #(
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       enable_we,
  input  logic       enable,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] ad_byte,
  output logic       first_of_ad,
  output logic       last_of_ad
);
  import sfad_pkg::*;

  logic  enable_reg;
  logic  full;
  logic  in_fire;
  push_t push;

  assign in_stall = full;
  assign in_fire  = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_reg <= 1'b0;
    end else if (enable_we) begin
      enable_reg <= enable;
    end
  end

  sfad_parse #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .rx_byte (rx_byte),
    .enable  (enable_reg),
    .push    (push)
  );

  sfad_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ad_byte     (ad_byte),
    .first_of_ad (first_of_ad),
    .last_of_ad  (last_of_ad)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the serial deframer and advertising wrapper against a cycle-free
// model of its parser. A short table of directed bytes comes first, then
// random frames, noise and broken syncs with random gaps on both channels.
// Every output transfer is compared field by field with the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module testbench;
  import sfad_pkg::*;

  localparam int unsigned BUF_BYTES  = 512;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned PHASE_ITEMS = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } ad_res_t;

  typedef struct packed {
    logic                is_cfg;
    logic [7:0]          data;
    logic                typed;
    logic [2:0]          n;
    ad_res_t [3:0]       res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       enable_we;
  logic       enable;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] ad_byte;
  logic       first_of_ad;
  logic       last_of_ad;

  // Parser model state
  phase_t      mdl_phase;
  logic [7:0]  mdl_type;
  logic [15:0] mdl_length;
  logic [8:0]  mdl_left;
  logic        mdl_fwd;
  logic        mdl_enable;

  ad_res_t  step_res[$];
  ad_res_t  ad_expected[$];
  dir_row_t dir_tab[$];

  int errors;
  int items_in;
  int results_seen;
  int headers_seen;
  int idle_cycles;
  int calm_left;

  serial_frame_to_ad_wrapper_core #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .enable_we  (enable_we),
    .enable     (enable),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ad_byte    (ad_byte),
    .first_of_ad(first_of_ad),
    .last_of_ad (last_of_ad)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the parser model by one byte; results land in step_res.
  function automatic void deframe_step(input logic [7:0] b);
    logic [15:0] len;
    logic        last;
    step_res.delete();
    case (mdl_phase)
      PH_HUNT_B: begin
        if (b == SYNC_B) mdl_phase = PH_TYPE;
        else if (b == SYNC_A) mdl_phase = PH_HUNT_B;
        else mdl_phase = PH_HUNT_A;
      end
      PH_TYPE: begin
        mdl_type  = b;
        mdl_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        mdl_length = {8'h00, b};
        mdl_phase  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len        = {b, mdl_length[7:0]};
        mdl_length = len;
        mdl_fwd    = 1'b0;
        if (len > BUF_BYTES - 5 || len == 0) begin
          mdl_left  = '0;
          mdl_phase = PH_HUNT_A;
        end else begin
          mdl_left  = len[8:0];
          mdl_phase = PH_BODY;
          if (mdl_enable && mdl_type == TYPE_INJECT && len <= MAX_PAYLOAD) begin
            mdl_fwd = 1'b1;
            step_res.push_back({len[7:0] + AD_LEN_ADD, 1'b1, 1'b0});
            step_res.push_back({AD_MANUF, 1'b0, 1'b0});
            step_res.push_back({SYNC_B, 1'b0, 1'b0});
            step_res.push_back({SYNC_A, 1'b0, 1'b0});
          end
        end
      end
      PH_BODY: begin
        last = (mdl_left <= 1);
        if (mdl_fwd) step_res.push_back({b, 1'b0, last});
        if (last) begin
          mdl_left  = '0;
          mdl_fwd   = 1'b0;
          mdl_phase = PH_HUNT_A;
        end else begin
          mdl_left = mdl_left - 1'b1;
        end
      end
      default: mdl_phase = (b == SYNC_A) ? PH_HUNT_B : PH_HUNT_A;
    endcase
  endfunction

  // Offer one byte, hold it until the transfer, then step the model.
  task automatic transfer_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_in++;
    deframe_step(b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    transfer_byte(b);
    foreach (step_res[k]) ad_expected.push_back(step_res[k]);
  endtask

  // Drain all results, let the block settle, then write enable.
  task automatic write_enable(input logic v);
    in_valid <= 1'b0;
    while (ad_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    enable_we <= 1'b1;
    enable    <= v;
    @(posedge clk);
    enable_we  <= 1'b0;
    mdl_enable = v;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len);
    int k;
    if ($urandom_range(0, 4) == 0) send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(ftype);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len != 0 && len <= BUF_BYTES - 5)
      for (k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic dir_row_t row_pred(input logic [7:0] b);
    row_pred      = '0;
    row_pred.data = b;
  endfunction

  function automatic dir_row_t row_quiet(input logic [7:0] b);
    row_quiet       = '0;
    row_quiet.data  = b;
    row_quiet.typed = 1'b1;
  endfunction

  function automatic dir_row_t row_pay(input logic [7:0] b, input logic last);
    row_pay        = '0;
    row_pay.data   = b;
    row_pay.typed  = 1'b1;
    row_pay.n      = 3'd1;
    row_pay.res[0] = {b, 1'b0, last};
  endfunction

  // Output side: random stall bursts with runs of free flow between them.
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Compare each output transfer with the oldest expected byte.
  ad_res_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (first_of_ad) headers_seen++;
      if (ad_expected.size() == 0) begin
        $error("unexpected transfer: ad_byte=%02h first=%0b last=%0b",
               ad_byte, first_of_ad, last_of_ad);
        errors++;
      end else begin
        want = ad_expected.pop_front();
        if (ad_byte !== want.data) begin
          $error("ad_byte: expected %02h, got %02h", want.data, ad_byte);
          errors++;
        end
        if (first_of_ad !== want.first) begin
          $error("first_of_ad: expected %0b, got %0b", want.first, first_of_ad);
          errors++;
        end
        if (last_of_ad !== want.last) begin
          $error("last_of_ad: expected %0b, got %0b", want.last, last_of_ad);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, ad_expected.size());
      $display("FAIL serial_frame_to_ad_wrapper_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t row;
    int       ph;
    int       goal;
    int       sel;
    int       k;
    logic [15:0] len;
    logic [7:0]  ftype;

    errors       = 0;
    items_in     = 0;
    results_seen = 0;
    headers_seen = 0;
    idle_cycles  = 0;
    calm_left    = 0;
    rst       <= 1'b1;
    enable_we <= 1'b0;
    enable    <= 1'b0;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h00;

    mdl_phase  = PH_HUNT_A;
    mdl_type   = '0;
    mdl_length = '0;
    mdl_left   = '0;
    mdl_fwd    = 1'b0;
    mdl_enable = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Inject frame right after reset: enable is still clear, so no output.
    dir_tab.push_back(row_quiet(SYNC_A));
    dir_tab.push_back(row_quiet(SYNC_B));
    dir_tab.push_back(row_quiet(TYPE_INJECT));
    dir_tab.push_back(row_quiet(8'h01));
    dir_tab.push_back(row_quiet(8'h00));
    dir_tab.push_back(row_quiet(8'hA5));
    row        = '0;
    row.is_cfg = 1'b1;
    row.data   = 8'h01;
    dir_tab.push_back(row);
    // Broken sync, then a repeated first sync byte ahead of a two byte frame.
    dir_tab.push_back(row_pred(SYNC_A));
    dir_tab.push_back(row_pred(8'h00));
    dir_tab.push_back(row_pred(SYNC_A));
    dir_tab.push_back(row_pred(SYNC_A));
    dir_tab.push_back(row_pred(SYNC_B));
    dir_tab.push_back(row_pred(TYPE_INJECT));
    dir_tab.push_back(row_pred(8'h02));
    row        = '0;
    row.data   = 8'h00;
    row.typed  = 1'b1;
    row.n      = 3'd4;
    row.res[0] = {8'h05, 1'b1, 1'b0};
    row.res[1] = {AD_MANUF, 1'b0, 1'b0};
    row.res[2] = {SYNC_B, 1'b0, 1'b0};
    row.res[3] = {SYNC_A, 1'b0, 1'b0};
    dir_tab.push_back(row);
    dir_tab.push_back(row_pay(8'h00, 1'b0));
    dir_tab.push_back(row_pay(8'hFF, 1'b1));
    // Empty frame closes at once.
    dir_tab.push_back(row_pred(SYNC_A));
    dir_tab.push_back(row_pred(SYNC_B));
    dir_tab.push_back(row_pred(TYPE_INJECT));
    dir_tab.push_back(row_pred(8'h00));
    dir_tab.push_back(row_quiet(8'h00));
    // Oversized length drops back to the hunt.
    dir_tab.push_back(row_pred(SYNC_A));
    dir_tab.push_back(row_pred(SYNC_B));
    dir_tab.push_back(row_pred(TYPE_INJECT));
    dir_tab.push_back(row_pred(8'hFF));
    dir_tab.push_back(row_quiet(8'hFF));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_enable(dir_tab[i].data[0]);
      end else begin
        transfer_byte(dir_tab[i].data);
        if (dir_tab[i].typed) begin
          for (k = 0; k < dir_tab[i].n; k++) ad_expected.push_back(dir_tab[i].res[k]);
        end else begin
          foreach (step_res[j]) ad_expected.push_back(step_res[j]);
        end
      end
    end

    // Random phases with enable set, clear, then set again.
    for (ph = 0; ph < 3; ph++) begin
      write_enable(ph != 1);
      goal = items_in + PHASE_ITEMS;
      if (ph == 0) begin
        send_frame(TYPE_INJECT, 16'(MAX_PAYLOAD));
      end
      while (items_in < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          ftype = ($urandom_range(0, 99) < 80) ? TYPE_INJECT : 8'($urandom_range(0, 255));
          sel = $urandom_range(0, 99);
          if (sel < 5) len = 16'd0;
          else if (sel < 10) len = 16'($urandom_range(BUF_BYTES - 4, 65535));
          else len = 16'($urandom_range(1, 12));
          send_frame(ftype, len);
        end else if (sel < 88) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          // Truncated header: whatever follows is read as the rest of it.
          send_byte(SYNC_A);
          if ($urandom_range(0, 1)) send_byte(SYNC_B);
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    in_valid <= 1'b0;
    while (ad_expected.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);

    $display("covered %0d input bytes, %0d output bytes checked, %0d wrapped headers",
             items_in, results_seen, headers_seen);
    $display("enable exercised clear and set, with random stalls on both channels");
    if (errors == 0) begin
      $display("PASS serial_frame_to_ad_wrapper_core");
    end else begin
      $display("FAIL serial_frame_to_ad_wrapper_core");
    end
    $finish;
  end

endmodule
